// ===== rtl/core/round_robin_task_scheduler_unit_assert.svh =====
// Assertion macros shared by the scheduler checker.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RRTS_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RRTS_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== rtl/core/rrts_pkg.sv =====
// Constants and codes of the round-robin task scheduler.
package rrts_pkg;
  localparam int Tasks = 16;
  localparam int IdxW  = $clog2(Tasks);
  localparam int CntW  = $clog2(Tasks + 1);
  localparam int TickW = 16;

  localparam logic [15:0] SliceReset = 16'd200;

  localparam logic [2:0] FuncTick   = 3'd0;
  localparam logic [2:0] FuncCreate = 3'd1;
  localparam logic [2:0] FuncFork   = 3'd2;
  localparam logic [2:0] FuncSleep  = 3'd3;
  localparam logic [2:0] FuncExit   = 3'd4;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatNoSlot = 2'd1;
  localparam logic [1:0] StatIdle   = 2'd2;
  localparam logic [1:0] StatBad    = 2'd3;
endpackage

// ===== rtl/core/round_robin_task_scheduler_unit.sv =====
// Round-robin task scheduler: list state and its sequencer.
//
// Usage: one request enters on the s_axis channel (func in tdata[2:0],
// sleep_ticks in tdata[18:3]) and produces exactly one response on the
// m_axis channel (running_task in tdata[3:0], new_task in tdata[7:4],
// status_code in tdata[9:8]). The time slice register is written over the
// cfg channel, which is always ready; the user must write it only while the
// block has no request in flight, and the block itself does not enforce this.
// Timing: a small sequencer handles one list update per cycle, except
// while it waits for the output register to free, through one shared
// decrement and link write path. A tick decrements the runner's slice and
// moves the runner to the ready tail when it runs out; otherwise it walks
// the sleep list and moves each sleeper that wakes to the ready tail.
// Create and fork scan upward from slot 1 for a free slot. The input is
// ready again as the response appears.
// The response sits in an output register, so a new request is taken while
// the previous response still waits; a stalled receiver only holds back the
// end of the following request. Reset leaves the idle task running alone,
// all other slots free and the time slice at 200.
module round_robin_task_scheduler_unit
  import rrts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // func [2:0], sleep_ticks [18:3], zeros
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // running_task [3:0], new_task [7:4],
                                       // status_code [9:8], zeros
);
  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] STick   = 4'd1;
  localparam logic [3:0] SRmRun  = 4'd2;
  localparam logic [3:0] SAppend = 4'd3;
  localparam logic [3:0] SWalk   = 4'd4;
  localparam logic [3:0] SScan   = 4'd5;
  localparam logic [3:0] SMerge  = 4'd6;
  localparam logic [3:0] SFin    = 4'd7;

  logic [3:0] state_q;
  logic [15:0] slice_q;
  logic [Tasks-1:0] used_q;
  logic [TickW-1:0] tk_q [Tasks];
  logic [IdxW-1:0]  nx_q [Tasks];
  logic [IdxW-1:0] run_tail_q, rdy_head_q, rdy_tail_q, slp_head_q, slp_tail_q;
  logic [CntW-1:0] run_cnt_q, rdy_cnt_q, slp_cnt_q, walk_k_q;
  logic [2:0] func_q;
  logic [15:0] sl_q;
  logic [IdxW-1:0] runner_q, cur_q, prev_q, app_task_q, scan_q, newt_q;
  logic has_prev_q, idle_q, app_ready_q;
  logic [3:0] ret_q;
  logic [1:0] status_q;
  logic out_valid_q;
  logic [15:0] out_data_q;

  // Shared decrement for the runner and the sleepers.
  logic [IdxW-1:0] dec_idx;
  logic [TickW-1:0] dec_val;
  logic accept, out_free;

  assign dec_idx = (state_q == STick) ? runner_q : cur_q;
  assign dec_val = tk_q[dec_idx] - 1'b1;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready_o = (state_q == SIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      slice_q <= SliceReset;
      used_q <= Tasks'(1);
      for (int i = 0; i < Tasks; i++) begin
        tk_q[i] <= '0;
        nx_q[i] <= '0;
      end
      run_tail_q <= '0;
      rdy_head_q <= '0;
      rdy_tail_q <= '0;
      slp_head_q <= '0;
      slp_tail_q <= '0;
      run_cnt_q <= CntW'(1);
      rdy_cnt_q <= '0;
      slp_cnt_q <= '0;
      walk_k_q <= '0;
      func_q <= '0;
      sl_q <= '0;
      runner_q <= '0;
      cur_q <= '0;
      prev_q <= '0;
      app_task_q <= '0;
      scan_q <= '0;
      newt_q <= '0;
      has_prev_q <= 1'b0;
      idle_q <= 1'b1;
      app_ready_q <= 1'b0;
      ret_q <= SIdle;
      status_q <= StatOk;
      out_valid_q <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        slice_q <= cfg_data_i;
      end
      // The final state loads the next response itself.
      if (out_valid_q && m_axis_tready_i && state_q != SFin) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (accept) begin
            func_q <= s_axis_tdata_i[2:0];
            sl_q <= s_axis_tdata_i[18:3];
            idle_q <= (run_cnt_q <= CntW'(1));
            runner_q <= (run_cnt_q > CntW'(1)) ? nx_q[0] : '0;
            newt_q <= '0;
            status_q <= StatOk;
            scan_q <= IdxW'(1);
            if (s_axis_tdata_i[2:0] == FuncTick) begin
              state_q <= STick;
            end else if (s_axis_tdata_i[2:0] == FuncCreate) begin
              state_q <= SScan;
            end else if (s_axis_tdata_i[2:0] == FuncFork ||
                         s_axis_tdata_i[2:0] == FuncSleep ||
                         s_axis_tdata_i[2:0] == FuncExit) begin
              // These act on the runner and are refused while idle runs.
              if (run_cnt_q <= CntW'(1)) begin
                status_q <= StatIdle;
                state_q <= SMerge;
              end else if (s_axis_tdata_i[2:0] == FuncFork) begin
                state_q <= SScan;
              end else begin
                state_q <= SRmRun;
              end
            end else begin
              state_q <= SMerge;
            end
          end
        end
        STick: begin
          if (!idle_q && dec_val == '0) begin
            // Slice used up: the runner goes to the ready tail.
            tk_q[runner_q] <= dec_val;
            state_q <= SRmRun;
          end else begin
            if (!idle_q) begin
              tk_q[runner_q] <= dec_val;
            end
            cur_q <= slp_head_q;
            has_prev_q <= 1'b0;
            walk_k_q <= slp_cnt_q;
            state_q <= SWalk;
          end
        end
        SRmRun: begin
          nx_q[0] <= nx_q[runner_q];
          if (run_tail_q == runner_q) begin
            run_tail_q <= '0;
          end
          run_cnt_q <= run_cnt_q - 1'b1;
          app_task_q <= runner_q;
          ret_q <= SMerge;
          if (func_q == FuncExit) begin
            tk_q[runner_q] <= '0;
            used_q[runner_q] <= 1'b0;
            state_q <= SMerge;
          end else if (func_q == FuncSleep) begin
            tk_q[runner_q] <= (sl_q == '0) ? TickW'(1) : sl_q;
            app_ready_q <= 1'b0;
            state_q <= SAppend;
          end else begin
            app_ready_q <= 1'b1;
            state_q <= SAppend;
          end
        end
        SAppend: begin
          if (app_ready_q) begin
            if (rdy_cnt_q == '0) begin
              rdy_head_q <= app_task_q;
            end else begin
              nx_q[rdy_tail_q] <= app_task_q;
            end
            rdy_tail_q <= app_task_q;
            rdy_cnt_q <= rdy_cnt_q + 1'b1;
            tk_q[app_task_q] <= slice_q;
          end else begin
            if (slp_cnt_q == '0) begin
              slp_head_q <= app_task_q;
            end else begin
              nx_q[slp_tail_q] <= app_task_q;
            end
            slp_tail_q <= app_task_q;
            slp_cnt_q <= slp_cnt_q + 1'b1;
          end
          state_q <= ret_q;
        end
        SWalk: begin
          if (walk_k_q == '0) begin
            state_q <= SMerge;
          end else begin
            walk_k_q <= walk_k_q - 1'b1;
            cur_q <= nx_q[cur_q];
            if (dec_val != '0) begin
              tk_q[cur_q] <= dec_val;
              prev_q <= cur_q;
              has_prev_q <= 1'b1;
            end else begin
              // Wake up: unlink from the sleep list, then join the ready tail.
              if (has_prev_q) begin
                nx_q[prev_q] <= nx_q[cur_q];
              end else begin
                slp_head_q <= nx_q[cur_q];
              end
              if (slp_tail_q == cur_q) begin
                slp_tail_q <= has_prev_q ? prev_q : '0;
              end
              slp_cnt_q <= slp_cnt_q - 1'b1;
              app_task_q <= cur_q;
              app_ready_q <= 1'b1;
              ret_q <= SWalk;
              state_q <= SAppend;
            end
          end
        end
        SScan: begin
          if (!used_q[scan_q]) begin
            nx_q[run_tail_q] <= scan_q;
            run_tail_q <= scan_q;
            run_cnt_q <= run_cnt_q + 1'b1;
            used_q[scan_q] <= 1'b1;
            tk_q[scan_q] <= (func_q == FuncCreate) ? slice_q : tk_q[runner_q];
            newt_q <= scan_q;
            state_q <= SMerge;
          end else if (scan_q == IdxW'(Tasks - 1)) begin
            status_q <= StatNoSlot;
            state_q <= SMerge;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        SMerge: begin
          // Only the idle task left to run: the ready list moves over whole.
          if (run_cnt_q == CntW'(1) && rdy_cnt_q != '0) begin
            nx_q[0] <= rdy_head_q;
            run_tail_q <= rdy_tail_q;
            run_cnt_q <= run_cnt_q + rdy_cnt_q;
            rdy_cnt_q <= '0;
            rdy_head_q <= '0;
            rdy_tail_q <= '0;
          end
          state_q <= SFin;
        end
        SFin: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q <= {6'd0, status_q, 4'(newt_q),
                           (run_cnt_q > CntW'(1)) ? 4'(nx_q[0]) : 4'd0};
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end
endmodule

// ===== rtl/core/rrts_checker.sv =====
// Port-level checker for the scheduler, with its bind.
`include "round_robin_task_scheduler_unit_assert.svh"

module rrts_checker
  import rrts_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);
  // A stalled response keeps its contents.
  `RRTS_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  // The status code has no fourth value.
  `RRTS_ASSERT_NOW(a_status_range, m_axis_tvalid_o, m_axis_tdata_o[9:8] != StatBad)
  // A refused or failed request hands out no slot.
  `RRTS_ASSERT_NOW(a_fail_no_slot, m_axis_tvalid_o && m_axis_tdata_o[9:8] != StatOk, m_axis_tdata_o[7:4] == 4'd0)
  // An accepted request closes the input until its response is loaded.
  `RRTS_ASSERT_NXT(a_busy_after, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
